// File: sv/apfb_pkg.sv
// Shared constants, codes and controller/datapath command types for the
// anti-aliased point frame buffer. No dependencies.
package apfb_pkg;

    localparam int COORD_W     = 20;
    localparam int CHAN_W      = 8;
    localparam int OP_W        = 3;
    localparam int PANEL_W     = 6;
    localparam int PIXEL_W     = 3 * CHAN_W;
    localparam int CFG_INDEX_W = 1;

    localparam int DEF_STORE_WIDTH   = 32;
    localparam int DEF_STORE_HEIGHT  = 32;
    localparam int DEF_FRACTION_BITS = 8;

    localparam logic [PANEL_W-1:0] PANEL_RESET = 6'd32;

    localparam logic [OP_W-1:0] OP_SET   = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 3'd1;
    localparam logic [OP_W-1:0] OP_SPLAT = 3'd2;
    localparam logic [OP_W-1:0] OP_FILL  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ  = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] REG_PANEL_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_PANEL_HEIGHT = 1'b1;

    localparam logic [1:0] TGT_BASE = 2'b00;
    localparam logic [1:0] TGT_LAST = 2'b11;

    typedef struct packed {
        logic       load_item;
        logic [1:0] tgt;
        logic       unit_weight;
        logic       calc_weight;
        logic       mem_rd;
        logic       calc_scale;
        logic       wr_set;
        logic       wr_add;
        logic       fill_start;
        logic       fill_step;
        logic       clr_step;
        logic       rsp_load;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            clr_last;
        logic            fill_last;
        logic            fill_empty;
    } status_t;

endpackage

// File: sv/apfb_ifs.sv
// Valid/ready channel interfaces for requests, responses and register writes.
// Depends on apfb_pkg.
interface apfb_req_if;
    import apfb_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           operation;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic [CHAN_W-1:0]         red;
    logic [CHAN_W-1:0]         green;
    logic [CHAN_W-1:0]         blue;
    modport source (output valid, operation, x_coord, y_coord, red, green, blue,
                    input ready);
    modport sink (input valid, operation, x_coord, y_coord, red, green, blue,
                  output ready);
endinterface

interface apfb_rsp_if;
    import apfb_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic              on_panel;
    modport source (output valid, out_red, out_green, out_blue, on_panel, input ready);
    modport sink (input valid, out_red, out_green, out_blue, on_panel, output ready);
endinterface

interface apfb_cfg_if;
    import apfb_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [PANEL_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: sv/antialiased_point_framebuffer_core.sv
// Top level of the anti-aliased point frame buffer.
// Depends on apfb_pkg, apfb_ifs, apfb_ctrl, apfb_datapath (with apfb_ram).
//
// One item at a time, one response per item. After reset the pixel store is
// cleared one pixel per cycle, all STORE_WIDTH * STORE_HEIGHT pixels (1024 by
// default), and no item is accepted until that pass ends; register writes are
// taken at any time. Set and read go through a decode state; saturating add
// and splat take, for each target pixel (one for add, four for splat), weight
// and read, scale, and write back through the store's single write port; fill
// writes each panel pixel in turn. The next item is accepted while the response
// waits.
module antialiased_point_framebuffer_core #(
    parameter int STORE_WIDTH   = apfb_pkg::DEF_STORE_WIDTH,
    parameter int STORE_HEIGHT  = apfb_pkg::DEF_STORE_HEIGHT,
    parameter int FRACTION_BITS = apfb_pkg::DEF_FRACTION_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    apfb_req_if.sink   request,
    apfb_rsp_if.source response,
    apfb_cfg_if.sink   config_wr
);
    import apfb_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign config_wr.ready = 1'b1;

    apfb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (request.ready),
        .rsp_valid (response.valid),
        .rsp_ready (response.ready),
        .status    (status),
        .cmd       (cmd)
    );

    apfb_datapath #(
        .STORE_WIDTH   (STORE_WIDTH),
        .STORE_HEIGHT  (STORE_HEIGHT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .operation (request.operation),
        .x_coord   (request.x_coord),
        .y_coord   (request.y_coord),
        .red       (request.red),
        .green     (request.green),
        .blue      (request.blue),
        .cfg_valid (config_wr.valid),
        .cfg_index (config_wr.index),
        .cfg_data  (config_wr.data),
        .out_red   (response.out_red),
        .out_green (response.out_green),
        .out_blue  (response.out_blue),
        .on_panel  (response.on_panel)
    );
endmodule

// File: sv/apfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module apfb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// File: sv/apfb_ctrl.sv
// Controller state machine: sequences clear, set, add, splat, fill and read.
// Depends on apfb_pkg; drives apfb_datapath through cmd_t.
module apfb_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    input  apfb_pkg::status_t status,
    output apfb_pkg::cmd_t   cmd
);
    import apfb_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_DECODE = 3'd2;
    localparam logic [2:0] ST_WEIGHT = 3'd3;
    localparam logic [2:0] ST_SCALE  = 3'd4;
    localparam logic [2:0] ST_WRITE  = 3'd5;
    localparam logic [2:0] ST_FILL   = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [1:0] tgt_reg, tgt_next;
    logic       rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        tgt_next       = tgt_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        req_ready      = 1'b0;
        cmd            = '0;
        cmd.tgt        = tgt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    tgt_next      = TGT_BASE;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (status.op) inside
                    OP_SET:
                    begin
                        cmd.wr_set = 1'b1;
                        state_next = ST_DONE;
                    end
                    OP_ADD, OP_SPLAT:
                    begin
                        state_next = ST_WEIGHT;
                    end
                    OP_FILL:
                    begin
                        cmd.fill_start = 1'b1;
                        state_next     = status.fill_empty ? ST_DONE : ST_FILL;
                    end
                    OP_READ:
                    begin
                        cmd.mem_rd = 1'b1;
                        state_next = ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_WEIGHT:
            begin
                cmd.calc_weight = 1'b1;
                cmd.unit_weight = (status.op == OP_ADD);
                cmd.mem_rd      = 1'b1;
                state_next      = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.calc_scale = 1'b1;
                state_next     = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.wr_add = 1'b1;
                if ((status.op == OP_SPLAT) && (tgt_reg != TGT_LAST))
                begin
                    tgt_next   = tgt_reg + 2'b01;
                    state_next = ST_WEIGHT;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (status.fill_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.rsp_load   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            tgt_reg       <= TGT_BASE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tgt_reg       <= tgt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
endmodule

// File: sv/apfb_datapath.sv
// Datapath: panel registers, item registers, bilinear weights, channel scaling,
// saturating add, fill and clear sweeps, pixel store. Depends on apfb_pkg, apfb_ram.
module apfb_datapath #(
    parameter int STORE_WIDTH   = apfb_pkg::DEF_STORE_WIDTH,
    parameter int STORE_HEIGHT  = apfb_pkg::DEF_STORE_HEIGHT,
    parameter int FRACTION_BITS = apfb_pkg::DEF_FRACTION_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  apfb_pkg::cmd_t                      cmd,
    output apfb_pkg::status_t                   status,
    input  logic [apfb_pkg::OP_W-1:0]           operation,
    input  logic signed [apfb_pkg::COORD_W-1:0] x_coord,
    input  logic signed [apfb_pkg::COORD_W-1:0] y_coord,
    input  logic [apfb_pkg::CHAN_W-1:0]         red,
    input  logic [apfb_pkg::CHAN_W-1:0]         green,
    input  logic [apfb_pkg::CHAN_W-1:0]         blue,
    input  logic                                cfg_valid,
    input  logic [apfb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [apfb_pkg::PANEL_W-1:0]        cfg_data,
    output logic [apfb_pkg::CHAN_W-1:0]         out_red,
    output logic [apfb_pkg::CHAN_W-1:0]         out_green,
    output logic [apfb_pkg::CHAN_W-1:0]         out_blue,
    output logic                                on_panel
);
    import apfb_pkg::*;

    localparam int DEPTH  = STORE_WIDTH * STORE_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW     = (STORE_WIDTH > 1) ? $clog2(STORE_WIDTH) : 1;
    localparam int YW     = (STORE_HEIGHT > 1) ? $clog2(STORE_HEIGHT) : 1;
    localparam int IW     = COORD_W - FRACTION_BITS;
    localparam int TW     = IW + 1;
    localparam int CMP_W  = (TW > 10) ? TW : 10;
    localparam int WW     = 2 * FRACTION_BITS + 1;
    localparam int PW     = CHAN_W + WW;

    localparam logic [FRACTION_BITS:0] UNIT    = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [WW-1:0]          UNIT_SQ = {1'b1, {(2 * FRACTION_BITS){1'b0}}};
    localparam logic [PW-1:0]          HALF    = PW'(1) << (2 * FRACTION_BITS - 1);
    localparam logic [CMP_W-1:0]       SW_C    = CMP_W'(STORE_WIDTH);
    localparam logic [CMP_W-1:0]       SH_C    = CMP_W'(STORE_HEIGHT);
    localparam logic [ADDR_W-1:0]      LAST_A  = ADDR_W'(DEPTH - 1);

    function automatic logic at_panel(input logic [TW-1:0] tx, input logic [TW-1:0] ty,
                                      input logic [CMP_W-1:0] w, input logic [CMP_W-1:0] h);
        return !tx[TW-1] && !ty[TW-1] && (CMP_W'(tx[TW-2:0]) < w)
               && (CMP_W'(ty[TW-2:0]) < h);
    endfunction

    function automatic logic [CHAN_W-1:0] scale_chan(input logic [CHAN_W-1:0] c,
                                                     input logic [WW-1:0] w);
        logic [PW-1:0] p;
        p = PW'(c) * PW'(w) + HALF;
        return p[2 * FRACTION_BITS +: CHAN_W];
    endfunction

    function automatic logic [CHAN_W-1:0] sat_add(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
        logic [CHAN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CHAN_W] ? {CHAN_W{1'b1}} : s[CHAN_W-1:0];
    endfunction

    logic [PANEL_W-1:0]       panel_width_reg, panel_width_next;
    logic [PANEL_W-1:0]       panel_height_reg, panel_height_next;
    logic [XW-1:0]            fill_x_reg, fill_x_next;
    logic [YW-1:0]            fill_y_reg, fill_y_next;
    logic [ADDR_W-1:0]        clr_reg, clr_next;

    logic [OP_W-1:0]          op_reg;
    logic [IW-1:0]            xi_reg, yi_reg;
    logic [FRACTION_BITS-1:0] fx_reg, fy_reg;
    logic [CHAN_W-1:0]        red_reg, green_reg, blue_reg;
    logic [WW-1:0]            weight_reg;
    logic [CHAN_W-1:0]        sc_red_reg, sc_green_reg, sc_blue_reg;
    logic [CHAN_W-1:0]        out_red_reg, out_green_reg, out_blue_reg;
    logic                     on_panel_reg;

    logic [CMP_W-1:0]         eff_w, eff_h;
    logic [TW-1:0]            base_x, base_y, tgt_x, tgt_y;
    logic                     base_on, tgt_on;
    logic [ADDR_W-1:0]        tgt_addr, fill_addr;
    logic                     fill_x_last, fill_y_last;
    logic [FRACTION_BITS:0]   wa, wb;
    logic [WW-1:0]            weight_calc;
    logic [PIXEL_W-1:0]       colour, rdata, wdata;
    logic [ADDR_W-1:0]        waddr;
    logic                     we;

    assign eff_w = (CMP_W'(panel_width_reg) > SW_C) ? SW_C : CMP_W'(panel_width_reg);
    assign eff_h = (CMP_W'(panel_height_reg) > SH_C) ? SH_C : CMP_W'(panel_height_reg);

    assign base_x  = {xi_reg[IW-1], xi_reg};
    assign base_y  = {yi_reg[IW-1], yi_reg};
    assign tgt_x   = base_x + TW'(cmd.tgt[0]);
    assign tgt_y   = base_y + TW'(cmd.tgt[1]);
    assign base_on = at_panel(base_x, base_y, eff_w, eff_h);
    assign tgt_on  = at_panel(tgt_x, tgt_y, eff_w, eff_h);

    assign tgt_addr = tgt_on
        ? ADDR_W'(int'(tgt_y[YW-1:0]) * STORE_WIDTH + int'(tgt_x[XW-1:0]))
        : '0;
    assign fill_addr = ADDR_W'(int'(fill_y_reg) * STORE_WIDTH + int'(fill_x_reg));

    assign fill_x_last = (CMP_W'(fill_x_reg) == eff_w - CMP_W'(1));
    assign fill_y_last = (CMP_W'(fill_y_reg) == eff_h - CMP_W'(1));

    assign wa = cmd.tgt[0] ? {1'b0, fx_reg} : UNIT - {1'b0, fx_reg};
    assign wb = cmd.tgt[1] ? {1'b0, fy_reg} : UNIT - {1'b0, fy_reg};
    assign weight_calc = cmd.unit_weight ? UNIT_SQ : WW'(WW'(wa) * WW'(wb));

    assign colour = {red_reg, green_reg, blue_reg};

    always_comb
    begin
        we    = 1'b0;
        waddr = tgt_addr;
        wdata = colour;
        if (cmd.clr_step)
        begin
            we    = 1'b1;
            waddr = clr_reg;
            wdata = '0;
        end
        else if (cmd.fill_step)
        begin
            we    = 1'b1;
            waddr = fill_addr;
        end
        else if (cmd.wr_set)
        begin
            we = tgt_on;
        end
        else if (cmd.wr_add)
        begin
            we    = tgt_on;
            wdata = {sat_add(rdata[2*CHAN_W +: CHAN_W], sc_red_reg),
                     sat_add(rdata[CHAN_W +: CHAN_W], sc_green_reg),
                     sat_add(rdata[0 +: CHAN_W], sc_blue_reg)};
        end
    end

    apfb_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.mem_rd),
        .raddr (tgt_addr),
        .rdata (rdata)
    );

    always_comb
    begin
        panel_width_next  = panel_width_reg;
        panel_height_next = panel_height_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PANEL_WIDTH:  panel_width_next  = cfg_data;
                REG_PANEL_HEIGHT: panel_height_next = cfg_data;
                default:          panel_width_next  = panel_width_reg;
            endcase
        end

        fill_x_next = fill_x_reg;
        fill_y_next = fill_y_reg;
        if (cmd.fill_start)
        begin
            fill_x_next = '0;
            fill_y_next = '0;
        end
        else if (cmd.fill_step)
        begin
            if (fill_x_last)
            begin
                fill_x_next = '0;
                fill_y_next = fill_y_reg + YW'(1);
            end
            else
            begin
                fill_x_next = fill_x_reg + XW'(1);
            end
        end

        clr_next = cmd.clr_step ? clr_reg + ADDR_W'(1) : clr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panel_width_reg  <= PANEL_RESET;
            panel_height_reg <= PANEL_RESET;
            fill_x_reg       <= '0;
            fill_y_reg       <= '0;
            clr_reg          <= '0;
        end
        else
        begin
            panel_width_reg  <= panel_width_next;
            panel_height_reg <= panel_height_next;
            fill_x_reg       <= fill_x_next;
            fill_y_reg       <= fill_y_next;
            clr_reg          <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg    <= operation;
            xi_reg    <= x_coord[COORD_W-1:FRACTION_BITS];
            yi_reg    <= y_coord[COORD_W-1:FRACTION_BITS];
            fx_reg    <= x_coord[FRACTION_BITS-1:0];
            fy_reg    <= y_coord[FRACTION_BITS-1:0];
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
        end
        if (cmd.calc_weight)
        begin
            weight_reg <= weight_calc;
        end
        if (cmd.calc_scale)
        begin
            sc_red_reg   <= scale_chan(red_reg, weight_reg);
            sc_green_reg <= scale_chan(green_reg, weight_reg);
            sc_blue_reg  <= scale_chan(blue_reg, weight_reg);
        end
        if (cmd.rsp_load)
        begin
            out_red_reg   <= ((op_reg == OP_READ) && base_on) ? rdata[2*CHAN_W +: CHAN_W] : '0;
            out_green_reg <= ((op_reg == OP_READ) && base_on) ? rdata[CHAN_W +: CHAN_W] : '0;
            out_blue_reg  <= ((op_reg == OP_READ) && base_on) ? rdata[0 +: CHAN_W] : '0;
            on_panel_reg  <= base_on && ((op_reg == OP_SET) || (op_reg == OP_ADD)
                             || (op_reg == OP_SPLAT) || (op_reg == OP_READ));
        end
    end

    assign status.op         = op_reg;
    assign status.clr_last   = (clr_reg == LAST_A);
    assign status.fill_last  = fill_x_last && fill_y_last;
    assign status.fill_empty = (eff_w == '0) || (eff_h == '0);

    assign out_red   = out_red_reg;
    assign out_green = out_green_reg;
    assign out_blue  = out_blue_reg;
    assign on_panel  = on_panel_reg;
endmodule

// File: sv/apfb_checker.sv
// Port-level assertions for the frame buffer core, bound to the top level.
// Depends on apfb_pkg and antialiased_point_framebuffer_core.
module apfb_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [apfb_pkg::CHAN_W-1:0] out_red,
    input logic [apfb_pkg::CHAN_W-1:0] out_green,
    input logic [apfb_pkg::CHAN_W-1:0] out_blue,
    input logic                        on_panel
);
    import apfb_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(out_red) && $stable(out_green)
                                    && $stable(out_blue) && $stable(on_panel))
        else $error("response payload changed while stalled");

    a_off_panel_black: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !on_panel |-> (out_red == '0) && (out_green == '0)
                                   && (out_blue == '0))
        else $error("nonzero colour without an on-panel pixel");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready && !$rose(rsp_valid))
        else $error("item overlap or early response");
endmodule

bind antialiased_point_framebuffer_core apfb_checker u_apfb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .rsp_valid (response.valid),
    .rsp_ready (response.ready),
    .out_red   (response.out_red),
    .out_green (response.out_green),
    .out_blue  (response.out_blue),
    .on_panel  (response.on_panel)
);
